// ===== design/ecc_error_dimm_locator_core_defines.svh =====
// ----------------------------------------------------------------------------
// ECC error DIMM locator: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ECC_ERROR_DIMM_LOCATOR_CORE_DEFINES_SVH
`define ECC_ERROR_DIMM_LOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define EEDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EEDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/eedl_pkg.sv =====
// ----------------------------------------------------------------------------
// ECC error DIMM locator package
// Widths, payload types, register indexes and decode functions.
// ----------------------------------------------------------------------------
`default_nettype none

package eedl_pkg;

   localparam int ADDR_BITS      = 44;
   localparam int BASE_SHIFT     = 24;
   localparam int BASE_HI_BITS   = ADDR_BITS - BASE_SHIFT;
   localparam int SYN_BITS       = 8;
   localparam int LANE_BITS      = 3;
   localparam int LANES          = 2 ** LANE_BITS;
   localparam int BANK_BITS      = 2;
   localparam int BANKS          = 2 ** BANK_BITS;
   localparam int DIMM_BITS      = 2;
   localparam int DIMM_SLOTS     = BANKS * (2 ** DIMM_BITS);
   localparam int COUNT_BITS     = 16;
   localparam int OUT_COUNT_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_DEPTH    = 2 ** QUEUE_PTR_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ZERO = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ONE  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_TWO  = 2'd2;

   localparam logic [BANK_BITS-1:0] BANK_NONE = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic [ADDR_BITS-1:0] fail_address;
      logic [SYN_BITS-1:0]  ecc_syndrome;
   } req_type;

   typedef struct packed {
      logic [LANE_BITS-1:0]      byte_lane;
      logic [BANK_BITS-1:0]      bank_index;
      logic [DIMM_BITS-1:0]      dimm_index;
      logic [OUT_COUNT_BITS-1:0] byte_lane_count;
      logic [OUT_COUNT_BITS-1:0] bank_count;
      logic [OUT_COUNT_BITS-1:0] dimm_count;
   } rsp_type;

   typedef struct packed {
      logic [LANE_BITS-1:0] byte_lane;
      logic [BANK_BITS-1:0] bank_index;
      logic [DIMM_BITS-1:0] dimm_index;
   } loc_type;

   function automatic logic [LANE_BITS-1:0] lane_table(input logic [2:0] idx);
      logic [LANE_BITS-1:0] lane;
      case (idx)
         3'd0:    lane = 3'd2;
         3'd1:    lane = 3'd1;
         3'd2:    lane = 3'd4;
         3'd3:    lane = 3'd7;
         3'd4:    lane = 3'd6;
         3'd5:    lane = 3'd5;
         3'd6:    lane = 3'd0;
         3'd7:    lane = 3'd3;
         default: lane = 3'd0;
      endcase
      return lane;
   endfunction

   function automatic logic [LANE_BITS-1:0] lane_decode(input logic [SYN_BITS-1:0] syn);
      logic [LANE_BITS-1:0] lane;
      lane = lane_table(syn[7:5]);
      for (int b = 0; b < SYN_BITS; b++) begin
         if (syn == (SYN_BITS'(1) << b)) begin
            lane = LANE_BITS'(b);
         end
      end
      return lane;
   endfunction

   function automatic logic [COUNT_BITS-1:0] count_bump(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_BITS'(1);
   endfunction

   function automatic logic [OUT_COUNT_BITS-1:0] count_out(input logic [COUNT_BITS-1:0] c);
      return OUT_COUNT_BITS'(c);
   endfunction

endpackage

`default_nettype wire

// ===== design/ecc_error_dimm_locator_core.sv =====
// A report with a nonzero syndrome is registered in a queue slot, then in the output register.
// Throughput: one report per cycle while the queue has room and results are taken; the
// counter stage's single read-modify-write per cycle on the lane, bank and DIMM counters
// sets that figure. A zero syndrome produces no result and leaves the counters untouched.
// Reset (synchronous, active high) clears base registers, counters and the queue.
// ----------------------------------------------------------------------------
// ECC error DIMM locator core
// Front end locates the error, a two-entry queue decouples it from the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ecc_error_dimm_locator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire eedl_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output eedl_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_write_enable,
   input  wire logic [eedl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [eedl_pkg::ADDR_BITS-1:0]      csr_write_data
);

   eedl_pkg::loc_type front_loc;
   eedl_pkg::loc_type q_loc;
   logic              front_valid;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   logic              q_push;

   eedl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .loc              (front_loc),
      .loc_valid        (front_valid)
   );

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready && front_valid;

   eedl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_loc  (front_loc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_loc   (q_loc),
      .not_empty (q_valid)
   );

   eedl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_loc       (q_loc),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== design/eedl_front.sv =====
// ----------------------------------------------------------------------------
// ECC error DIMM locator: front end
// Holds the array bases, decodes the byte lane and locates bank and DIMM.
// ----------------------------------------------------------------------------
`default_nettype none

module eedl_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [eedl_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [eedl_pkg::ADDR_BITS-1:0]         csr_write_data,
   input  wire eedl_pkg::req_type                      req_payload,
   output eedl_pkg::loc_type                           loc,
   output logic                                        loc_valid
);

   logic [eedl_pkg::BASE_HI_BITS-1:0] base_ff [3];
   logic [eedl_pkg::BASE_HI_BITS-1:0] addr_hi;
   logic [eedl_pkg::BANK_BITS-1:0]    o0, o1, o2, tmp;
   logic [eedl_pkg::BANK_BITS-1:0]    bank;
   logic [eedl_pkg::LANE_BITS-1:0]    lane;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            base_ff[i] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            eedl_pkg::CSR_BASE_ZERO:
               base_ff[0] <= csr_write_data[eedl_pkg::ADDR_BITS-1:eedl_pkg::BASE_SHIFT];
            eedl_pkg::CSR_BASE_ONE:
               base_ff[1] <= csr_write_data[eedl_pkg::ADDR_BITS-1:eedl_pkg::BASE_SHIFT];
            eedl_pkg::CSR_BASE_TWO:
               base_ff[2] <= csr_write_data[eedl_pkg::ADDR_BITS-1:eedl_pkg::BASE_SHIFT];
            default: ;
         endcase
      end
   end

   assign addr_hi = req_payload.fail_address[eedl_pkg::ADDR_BITS-1:eedl_pkg::BASE_SHIFT];

   // order the bases: two swaps against the first slot, then the tail
   always_comb begin
      o0 = 2'd0;
      o1 = 2'd1;
      o2 = 2'd2;
      tmp = '0;
      if (base_ff[o1] < base_ff[o0]) begin
         tmp = o1;
         o1  = o0;
         o0  = tmp;
      end
      if (base_ff[o2] < base_ff[o0]) begin
         tmp = o2;
         o2  = o0;
         o0  = tmp;
      end
      if (base_ff[o2] < base_ff[o1]) begin
         tmp = o2;
         o2  = o1;
         o1  = tmp;
      end
   end

   always_comb begin
      bank = eedl_pkg::BANK_NONE;
      if (addr_hi >= base_ff[o0] && base_ff[o1] > addr_hi) begin
         bank = o0;
      end
      if (addr_hi >= base_ff[o1] && base_ff[o2] > addr_hi) begin
         bank = o1;
      end
   end

   assign lane           = eedl_pkg::lane_decode(req_payload.ecc_syndrome);
   assign loc.byte_lane  = lane;
   assign loc.bank_index = bank;
   assign loc.dimm_index = {lane[0], req_payload.fail_address[4]};
   assign loc_valid      = (req_payload.ecc_syndrome != '0);

endmodule

`default_nettype wire

// ===== design/eedl_queue.sv =====
// ----------------------------------------------------------------------------
// ECC error DIMM locator: location queue
// Short queue that decouples the front end from the counter stage.
// ----------------------------------------------------------------------------
`default_nettype none

module eedl_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire eedl_pkg::loc_type push_loc,
   output logic                   full,
   input  wire logic              pop,
   output eedl_pkg::loc_type      pop_loc,
   output logic                   not_empty
);

   eedl_pkg::loc_type                    slot_ff [eedl_pkg::QUEUE_DEPTH];
   logic [eedl_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [eedl_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [eedl_pkg::QUEUE_PTR_BITS:0]    level_ff, level_in;

   assign full      = (level_ff == (eedl_pkg::QUEUE_PTR_BITS + 1)'(eedl_pkg::QUEUE_DEPTH));
   assign not_empty = (level_ff != '0);
   assign pop_loc   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_loc;
      end
   end

endmodule

`default_nettype wire

// ===== design/eedl_back.sv =====
// ----------------------------------------------------------------------------
// ECC error DIMM locator: counter stage
// Bumps the saturating lane, bank and DIMM counters and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module eedl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire eedl_pkg::loc_type q_loc,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output eedl_pkg::rsp_type      rsp_payload
);

   logic [eedl_pkg::COUNT_BITS-1:0] lane_cnt_ff [eedl_pkg::LANES];
   logic [eedl_pkg::COUNT_BITS-1:0] bank_cnt_ff [eedl_pkg::BANKS];
   logic [eedl_pkg::COUNT_BITS-1:0] dimm_cnt_ff [eedl_pkg::DIMM_SLOTS];
   logic [eedl_pkg::COUNT_BITS-1:0] lane_cnt_in, bank_cnt_in, dimm_cnt_in;
   logic [eedl_pkg::BANK_BITS+eedl_pkg::DIMM_BITS-1:0] dimm_slot;
   logic                            rsp_valid_ff, rsp_valid_in;
   eedl_pkg::rsp_type               rsp_ff;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_ready);
   assign dimm_slot = {q_loc.bank_index, q_loc.dimm_index};

   assign lane_cnt_in = eedl_pkg::count_bump(lane_cnt_ff[q_loc.byte_lane]);
   assign bank_cnt_in = eedl_pkg::count_bump(bank_cnt_ff[q_loc.bank_index]);
   assign dimm_cnt_in = eedl_pkg::count_bump(dimm_cnt_ff[dimm_slot]);

   assign rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < eedl_pkg::LANES; i++) begin
            lane_cnt_ff[i] <= '0;
         end
         for (int i = 0; i < eedl_pkg::BANKS; i++) begin
            bank_cnt_ff[i] <= '0;
         end
         for (int i = 0; i < eedl_pkg::DIMM_SLOTS; i++) begin
            dimm_cnt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            lane_cnt_ff[q_loc.byte_lane]  <= lane_cnt_in;
            bank_cnt_ff[q_loc.bank_index] <= bank_cnt_in;
            dimm_cnt_ff[dimm_slot]        <= dimm_cnt_in;
         end
      end
   end

   // load the output register on each transfer out of the queue
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff.byte_lane       <= q_loc.byte_lane;
         rsp_ff.bank_index      <= q_loc.bank_index;
         rsp_ff.dimm_index      <= q_loc.dimm_index;
         rsp_ff.byte_lane_count <= eedl_pkg::count_out(lane_cnt_in);
         rsp_ff.bank_count      <= eedl_pkg::count_out(bank_cnt_in);
         rsp_ff.dimm_count      <= eedl_pkg::count_out(dimm_cnt_in);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== design/eedl_checker.sv =====
// ----------------------------------------------------------------------------
// ECC error DIMM locator: port checker
// Watches the top level's ports and is bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ecc_error_dimm_locator_core_defines.svh"

module eedl_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire eedl_pkg::rsp_type rsp_payload
);

   `EEDL_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid, "report withdrawn before transfer")

   `EEDL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result dropped or changed while stalled")

   `EEDL_ASSERT_NOW(a_dimm_lane, clock, reset, rsp_valid, rsp_payload.dimm_index[1] == rsp_payload.byte_lane[0], "DIMM index upper bit does not follow lane bit 0")

   `EEDL_ASSERT_NOW(a_counts_live, clock, reset, rsp_valid, rsp_payload.byte_lane_count != '0 && rsp_payload.bank_count != '0 && rsp_payload.dimm_count != '0, "result carries a zero count")

   `EEDL_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid, "result present straight after reset")

endmodule

bind ecc_error_dimm_locator_core eedl_checker u_eedl_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_ecc_error_dimm_locator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ECC error DIMM locator core testbench
// Drives error reports through valid/ready with bursty input and a stalling
// output, steps through a series of array base settings (all-zero, all-ones,
// ordered, reversed, equal and random), and checks every result field against
// a locator and counter model kept alongside.
// ----------------------------------------------------------------------------

module tb_ecc_error_dimm_locator_core;

   localparam logic [eedl_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam logic [eedl_pkg::ADDR_BITS-1:0] ADDR_ONES = {eedl_pkg::ADDR_BITS{1'b1}};
   localparam logic [eedl_pkg::ADDR_BITS-1:0] BASE_KEEP = ADDR_ONES << eedl_pkg::BASE_SHIFT;
   // lane for syndrome bits 7..5 when the syndrome is not one-hot
   localparam logic [23:0] LANE_OF_TOP = {3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd1, 3'd2};
   localparam int DIRECTED_ROWS      = 20;
   localparam int PHASES             = 9;
   localparam int PHASE_REPORTS      = 190;
   localparam int LONG_HOLD          = 400;
   localparam int DRAIN_CYCLES       = 8;

   typedef struct packed {
      eedl_pkg::req_type report;
      logic              typed;
      eedl_pkg::rsp_type answer;
   } vector_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   eedl_pkg::req_type                   req_payload;
   logic                                rsp_valid;
   logic                                rsp_ready;
   eedl_pkg::rsp_type                   rsp_payload;
   logic                                csr_write_enable;
   logic [eedl_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [eedl_pkg::ADDR_BITS-1:0]      csr_write_data;

   logic [eedl_pkg::ADDR_BITS-1:0]  array_base [3];
   logic [eedl_pkg::COUNT_BITS-1:0] lane_tally [eedl_pkg::LANES];
   logic [eedl_pkg::COUNT_BITS-1:0] bank_tally [eedl_pkg::BANKS];
   logic [eedl_pkg::COUNT_BITS-1:0] dimm_tally [eedl_pkg::DIMM_SLOTS];
   eedl_pkg::rsp_type               pending_locations [$];
   vector_row_type                  directed_rows [DIRECTED_ROWS];

   int failures        = 0;
   int results_checked = 0;
   int reports_sent    = 0;
   int silent_reports  = 0;
   int stall_mode      = 0;
   int holds_asked     = 0;
   int holds_served    = 0;

   ecc_error_dimm_locator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [eedl_pkg::COUNT_BITS-1:0] saturate_up(
      input logic [eedl_pkg::COUNT_BITS-1:0] c);
      return (c == {eedl_pkg::COUNT_BITS{1'b1}}) ? c : c + 1'b1;
   endfunction

   // locate one report, advance the tallies; returns 0 when no result is due
   function automatic logic locate_report(input eedl_pkg::req_type r,
                                          output eedl_pkg::rsp_type loc);
      logic [eedl_pkg::ADDR_BITS-1:0] masked [3];
      int                             order [3];
      int                             swap;
      int                             bank;
      int                             slot;
      logic [eedl_pkg::LANE_BITS-1:0] lane;
      loc = '0;
      if (r.ecc_syndrome == '0) return 1'b0;
      lane = LANE_OF_TOP[int'(r.ecc_syndrome[7:5]) * 3 +: 3];
      for (int b = 0; b < eedl_pkg::SYN_BITS; b++) begin
         if (r.ecc_syndrome == (eedl_pkg::SYN_BITS'(1) << b)) lane = eedl_pkg::LANE_BITS'(b);
      end
      for (int k = 0; k < 3; k++) begin
         masked[k] = array_base[k] & BASE_KEEP;
         order[k]  = k;
      end
      for (int k = 1; k < 3; k++) begin
         if (masked[order[k]] < masked[order[0]]) begin
            swap     = order[k];
            order[k] = order[0];
            order[0] = swap;
         end
      end
      if (masked[order[2]] < masked[order[1]]) begin
         swap     = order[2];
         order[2] = order[1];
         order[1] = swap;
      end
      bank = int'(eedl_pkg::BANK_NONE);
      for (int k = 0; k < 2; k++) begin
         if (r.fail_address >= masked[order[k]] && r.fail_address < masked[order[k+1]])
            bank = order[k];
      end
      loc.byte_lane  = lane;
      loc.bank_index = eedl_pkg::BANK_BITS'(bank);
      loc.dimm_index = {lane[0], r.fail_address[4]};
      slot = bank * 4 + int'(loc.dimm_index);
      lane_tally[lane] = saturate_up(lane_tally[lane]);
      bank_tally[bank] = saturate_up(bank_tally[bank]);
      dimm_tally[slot] = saturate_up(dimm_tally[slot]);
      loc.byte_lane_count = eedl_pkg::OUT_COUNT_BITS'(lane_tally[lane]);
      loc.bank_count      = eedl_pkg::OUT_COUNT_BITS'(bank_tally[bank]);
      loc.dimm_count      = eedl_pkg::OUT_COUNT_BITS'(dimm_tally[slot]);
      return 1'b1;
   endfunction

   function automatic eedl_pkg::req_type make_report();
      eedl_pkg::req_type              r;
      logic [eedl_pkg::ADDR_BITS-1:0] anchor;
      anchor = array_base[2'($urandom_range(0, 2))] & BASE_KEEP;
      case ($urandom_range(0, 5))
         0:       r.fail_address = eedl_pkg::ADDR_BITS'({$urandom, $urandom});
         1:       r.fail_address = anchor;
         2:       r.fail_address = anchor - eedl_pkg::ADDR_BITS'(1)
                                   - eedl_pkg::ADDR_BITS'($urandom_range(0, 255));
         3:       r.fail_address = {anchor[eedl_pkg::ADDR_BITS-1:eedl_pkg::BASE_SHIFT],
                                    24'($urandom)};
         4:       r.fail_address = anchor + {20'($urandom_range(1, 3)), 24'($urandom)};
         default: r.fail_address = anchor - eedl_pkg::ADDR_BITS'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       r.ecc_syndrome = '0;
         1, 2, 3: r.ecc_syndrome = eedl_pkg::SYN_BITS'(1) << $urandom_range(0, 7);
         default: r.ecc_syndrome = eedl_pkg::SYN_BITS'($urandom);
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic write_register(input logic [eedl_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [eedl_pkg::ADDR_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      if (idx != CSR_UNUSED) array_base[idx] = value;
   endtask

   task automatic apply_bases(input logic [eedl_pkg::ADDR_BITS-1:0] b0, b1, b2);
      write_register(eedl_pkg::CSR_BASE_ZERO, b0);
      write_register(eedl_pkg::CSR_BASE_ONE, b1);
      write_register(eedl_pkg::CSR_BASE_TWO, b2);
      write_register(CSR_UNUSED, eedl_pkg::ADDR_BITS'({$urandom, $urandom}));
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_report(input eedl_pkg::req_type r, input logic typed,
                              input eedl_pkg::rsp_type answer);
      eedl_pkg::rsp_type loc;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      reports_sent++;
      if (locate_report(r, loc)) pending_locations.push_back(typed ? answer : loc);
      else silent_reports++;
   endtask

   task automatic rest_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_quiet();
      while (pending_locations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: stall pattern per phase, plus the long hold on request
   initial begin
      int         run_left;
      logic       level;
      logic [7:0] rota;
      run_left  = 0;
      level     = 1'b1;
      rota      = 8'b1011_0011;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_asked != holds_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            holds_served++;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: begin
                  rsp_ready <= rota[0];
                  rota = {rota[0], rota[7:1]};
               end
               default: begin
                  if (run_left == 0) begin
                     level    = 1'($urandom_range(0, 1));
                     run_left = $urandom_range(1, 16);
                  end
                  run_left--;
                  rsp_ready <= level;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      eedl_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_locations.size() == 0) begin
            $error("result transfer with no report waiting: %h", rsp_payload);
            failures++;
         end else begin
            want = pending_locations.pop_front();
            compare_field("byte_lane", 16'(want.byte_lane), 16'(rsp_payload.byte_lane));
            compare_field("bank_index", 16'(want.bank_index), 16'(rsp_payload.bank_index));
            compare_field("dimm_index", 16'(want.dimm_index), 16'(rsp_payload.dimm_index));
            compare_field("byte_lane_count", want.byte_lane_count,
                          rsp_payload.byte_lane_count);
            compare_field("bank_count", want.bank_count, rsp_payload.bank_count);
            compare_field("dimm_count", want.dimm_count, rsp_payload.dimm_count);
            results_checked++;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [eedl_pkg::ADDR_BITS-1:0] b0;
      logic [eedl_pkg::ADDR_BITS-1:0] b1;
      logic [eedl_pkg::ADDR_BITS-1:0] b2;
      int                             burst;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      for (int k = 0; k < 3; k++) array_base[k] = '0;
      for (int k = 0; k < eedl_pkg::LANES; k++) lane_tally[k] = '0;
      for (int k = 0; k < eedl_pkg::BANKS; k++) bank_tally[k] = '0;
      for (int k = 0; k < eedl_pkg::DIMM_SLOTS; k++) dimm_tally[k] = '0;

      // bases are zero here, so every located report falls in the spare bank
      directed_rows = '{
         {44'h000_0000_0000, 8'h01, 1'b1, 3'd0, eedl_pkg::BANK_NONE, 2'd0,
          16'd1, 16'd1, 16'd1},
         {44'hFFF_FFFF_FFFF, 8'h80, 1'b1, 3'd7, eedl_pkg::BANK_NONE, 2'd3,
          16'd1, 16'd2, 16'd1},
         {44'hFFF_FFFF_FFFF, 8'h00, 1'b0, 55'd0},
         {44'h000_0000_0010, 8'hFF, 1'b1, 3'd3, eedl_pkg::BANK_NONE, 2'd3,
          16'd1, 16'd3, 16'd2},
         {44'h000_0000_0000, 8'h02, 1'b1, 3'd1, eedl_pkg::BANK_NONE, 2'd2,
          16'd1, 16'd4, 16'd1},
         {44'hAAA_AAAA_AAAA, 8'h04, 1'b0, 55'd0},
         {44'h555_5555_5555, 8'h08, 1'b0, 55'd0},
         {44'h000_00FF_FFFF, 8'h10, 1'b0, 55'd0},
         {44'hFFF_FF00_0000, 8'h20, 1'b0, 55'd0},
         {44'h123_4567_89AB, 8'h40, 1'b0, 55'd0},
         {44'h000_0000_0000, 8'h03, 1'b0, 55'd0},
         {44'hFFF_FFFF_FFEF, 8'h23, 1'b0, 55'd0},
         {44'h000_0000_0010, 8'h43, 1'b0, 55'd0},
         {44'h800_0000_0000, 8'h63, 1'b0, 55'd0},
         {44'h7FF_FFFF_FFFF, 8'h83, 1'b0, 55'd0},
         {44'h000_0100_0000, 8'hA3, 1'b0, 55'd0},
         {44'h000_00FF_FFEF, 8'hC3, 1'b0, 55'd0},
         {44'hFFF_FFFF_FFFF, 8'hE3, 1'b0, 55'd0},
         {44'h000_0000_0000, 8'h00, 1'b0, 55'd0},
         {44'h0F0_F0F0_F0F0, 8'hFE, 1'b0, 55'd0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      stall_mode = 1;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_report(directed_rows[i].report, directed_rows[i].typed,
                     directed_rows[i].answer);
      rest_sender(1);
      wait_quiet();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               b0 = ADDR_ONES;
               b1 = ADDR_ONES;
               b2 = ADDR_ONES;
            end
            1: begin
               b0 = {20'h00001, 24'($urandom)};
               b1 = {20'h00003, 24'($urandom)};
               b2 = {20'h00006, 24'($urandom)};
            end
            2: begin
               b0 = {20'h0000C, 24'($urandom)};
               b1 = {20'h00005, 24'($urandom)};
               b2 = {20'h00002, 24'($urandom)};
            end
            3: begin
               b0 = '0;
               b1 = ADDR_ONES;
               b2 = {20'h00004, 24'($urandom)};
            end
            4: begin
               b0 = {20'h00002, 24'($urandom)};
               b1 = {20'h00008, 24'($urandom)};
               b2 = {20'h00002, 24'($urandom)};
            end
            5: begin
               b0 = {20'h00007, 24'($urandom)};
               b1 = {20'h00007, 24'($urandom)};
               b2 = {20'h00007, 24'($urandom)};
            end
            6, 7: begin
               b0 = {20'($urandom_range(0, 15)), 24'($urandom)};
               b1 = {20'($urandom_range(0, 15)), 24'($urandom)};
               b2 = {20'($urandom_range(0, 15)), 24'($urandom)};
            end
            default: begin
               b0 = eedl_pkg::ADDR_BITS'({$urandom, $urandom});
               b1 = eedl_pkg::ADDR_BITS'({$urandom, $urandom});
               b2 = eedl_pkg::ADDR_BITS'({$urandom, $urandom});
            end
         endcase
         apply_bases(b0, b1, b2);
         stall_mode = phase % 4;
         if (phase == 1) holds_asked++;
         burst = 0;
         for (int n = 0; n < PHASE_REPORTS; n++) begin
            if (phase == 5 && n == PHASE_REPORTS / 2) begin
               rest_sender(1);
               wait_quiet();
            end
            send_report(make_report(), 1'b0, '0);
            if (phase % 3 != 0) begin
               if (burst == 0) begin
                  burst = $urandom_range(1, 24);
                  rest_sender($urandom_range(1, 8));
               end else begin
                  burst--;
               end
            end
         end
         rest_sender(1);
         wait_quiet();
      end

      $display("Sent %0d reports (%0d directed, %0d with zero syndrome) over %0d base settings",
               reports_sent, DIRECTED_ROWS, silent_reports, PHASES + 1);
      $display("with bursty input and stalled output; %0d results checked, %0d mismatches.",
               results_checked, failures);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
